// ===== rtl/fst_pkg.sv =====
`timescale 1ns / 1ps
package fst_pkg;

    // Result status codes.
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_SWEPT   = 2'd3;

    // Input item kinds.
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    localparam logic [47:0] TIMEOUT_RESET = 48'd2500000000;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [47:0] now;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [15:0] pkt_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] flow_packets;
        logic [47:0] flow_bytes;
        logic [10:0] live_count;
        logic [10:0] evicted_count;
    } t_out_item;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_UPDATE,
        S_SWEEP,
        S_SWEEP_WAIT,
        S_OUT,
        S_CLEAR
    } t_state;

endpackage

// ===== rtl/flow_stats_table_with_aging.sv =====
`timescale 1ns / 1ps
// Flow statistics table with idle-timeout aging.
// Input channel: drive i_item and raise push; the beat is taken on a clock
// edge with push high and full low. A two-entry input queue lets the source
// hand over two items while the table works on an earlier one.
// Result channel: while empty is low the oldest result sits on o_result; it
// is taken on an edge with pop high. Exactly one result per item, in order.
// The engine handles one item at a time and scans the entry memory one entry
// per cycle. A packet's scan stops at the entry that holds its flow; a new
// flow or a drop scans the whole table, as does a sweep. The engine takes the
// next item only once the result of the last one has been taken.
// A new flow takes the lowest free entry.
// i_idle_timeout_we writes the idle timeout; write it only while idle.
// Reset (synchronous, active low) clears the live count and the input queue,
// sets the timeout to 2500000000 ticks and starts a clearing pass that marks
// every entry free.
// While the receiver holds off pop, the result waits and the engine stops;
// the input queue keeps accepting until it is full.
module flow_stats_table_with_aging #(
    parameter int ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  fst_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output fst_pkg::t_out_item o_result,
    input  logic               i_idle_timeout_we,
    input  logic [47:0]        i_idle_timeout
);

    logic              w_avail;
    logic              w_take;
    logic              w_res_valid;
    fst_pkg::t_in_item w_item;
    logic [47:0]       r_timeout;

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= fst_pkg::TIMEOUT_RESET;
        end else if (i_idle_timeout_we) begin
            r_timeout <= i_idle_timeout;
        end
    end

    fst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (w_take),
        .o_avail (w_avail),
        .o_item  (w_item)
    );

    fst_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timeout   (r_timeout),
        .i_avail     (w_avail),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (o_result),
        .i_res_take  (pop)
    );

    assign empty = !w_res_valid;

endmodule

// ===== rtl/fst_front.sv =====
`timescale 1ns / 1ps
// Input side: a two-entry queue that takes items while the back end works.
module fst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fst_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_take,
    output logic              o_avail,
    output fst_pkg::t_in_item o_item
);

    fst_pkg::t_in_item r_slot [2];
    logic              r_rd;
    logic              r_wr;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              w_push;
    logic              w_take;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_avail;

    // Occupancy follows the push and take beats.
    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_take) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !i_push) |=> r_cnt == 2'd0) else $error("count moved");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_take) |=> o_full) else $error("full dropped without take");

endmodule

// ===== rtl/fst_back.sv =====
`timescale 1ns / 1ps
// Table engine: clears the entry memory after reset, scans it one entry per
// cycle for a key match and a free slot, then read-modify-writes the flow; a
// sweep walks all entries and frees the idle ones.
module fst_back #(
    parameter int ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [47:0]        i_timeout,
    input  logic               i_avail,
    input  fst_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_res_valid,
    output fst_pkg::t_out_item o_res,
    input  logic               i_res_take
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW:0] LAST = (AW+1)'(ENTRIES - 1);

    typedef struct packed {
        logic        valid;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [31:0] port_pair;
        logic [7:0]  proto;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [47:0] seen_at;
    } t_entry;

    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;

    fst_pkg::t_state    r_state;
    fst_pkg::t_state    n_state;
    fst_pkg::t_in_item  r_item;
    logic [AW:0]        r_addr;
    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    logic               r_free;
    logic [AW-1:0]      r_free_idx;
    logic [CW-1:0]      r_live;
    logic [CW-1:0]      r_evict;
    fst_pkg::t_out_item r_res;

    logic               w_rd_en;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_idx;
    t_entry             w_wr_data;
    logic               w_key_eq;
    logic               w_evict;
    logic [47:0]        w_idle;
    logic [AW-1:0]      w_idx;
    logic [AW-1:0]      w_upd_idx;
    logic [32:0]        w_pk_sum;
    logic [48:0]        w_by_sum;
    t_entry             w_base;
    t_entry             w_new;

    assign w_idx    = r_addr[AW-1:0];
    assign w_key_eq = r_rd_vld && r_rd_data.valid
                      && r_rd_data.saddr == r_item.saddr
                      && r_rd_data.daddr == r_item.daddr
                      && r_rd_data.port_pair == {r_item.sport, r_item.dport}
                      && r_rd_data.proto == r_item.proto;
    assign w_idle   = r_item.now - r_rd_data.seen_at;

    // A sweep frees a valid entry whose idle time is over the timeout.
    assign w_evict  = (r_state inside {fst_pkg::S_SWEEP, fst_pkg::S_SWEEP_WAIT})
                      && r_rd_vld && r_rd_data.valid && w_idle > i_timeout;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fst_pkg::S_CLEAR: begin
                if (r_addr == LAST) begin
                    n_state = fst_pkg::S_IDLE;
                end
            end
            fst_pkg::S_IDLE: begin
                if (i_avail) begin
                    n_state = (i_item.kind == fst_pkg::KIND_SWEEP) ?
                              fst_pkg::S_SWEEP : fst_pkg::S_SCAN;
                end
            end
            fst_pkg::S_SCAN: begin
                if (w_key_eq) begin
                    n_state = fst_pkg::S_UPDATE;
                end else if (r_addr == LAST) begin
                    n_state = fst_pkg::S_SCAN_WAIT;
                end
            end
            fst_pkg::S_SCAN_WAIT: begin
                n_state = fst_pkg::S_UPDATE;
            end
            fst_pkg::S_UPDATE: n_state = fst_pkg::S_OUT;
            fst_pkg::S_SWEEP: begin
                if (r_addr == LAST) begin
                    n_state = fst_pkg::S_SWEEP_WAIT;
                end
            end
            fst_pkg::S_SWEEP_WAIT: n_state = fst_pkg::S_OUT;
            fst_pkg::S_OUT: begin
                if (i_res_take) begin
                    n_state = fst_pkg::S_IDLE;
                end
            end
            default: n_state = fst_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_take      = 1'b0;
        o_res_valid = 1'b0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        case (r_state)
            fst_pkg::S_CLEAR: w_wr_en = 1'b1;
            fst_pkg::S_IDLE: o_take = i_avail;
            fst_pkg::S_SCAN: w_rd_en = !w_key_eq;
            fst_pkg::S_UPDATE: w_wr_en = r_hit || r_free;
            fst_pkg::S_SWEEP: begin
                w_rd_en = 1'b1;
                w_wr_en = w_evict;
            end
            fst_pkg::S_SWEEP_WAIT: w_wr_en = w_evict;
            fst_pkg::S_OUT: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    // Updated entry contents with saturating counters.
    assign w_upd_idx = r_hit ? r_hit_idx : r_free_idx;
    always_comb begin
        w_base = r_rd_data;
        if (!r_hit) begin
            w_base.saddr     = r_item.saddr;
            w_base.daddr     = r_item.daddr;
            w_base.port_pair = {r_item.sport, r_item.dport};
            w_base.proto     = r_item.proto;
            w_base.packets   = '0;
            w_base.bytes     = '0;
        end
        w_pk_sum = {1'b0, w_base.packets} + 33'd1;
        w_by_sum = {1'b0, w_base.bytes} + {33'd0, r_item.pkt_bytes};
        w_new = w_base;
        w_new.valid     = 1'b1;
        w_new.packets   = w_pk_sum[32] ? fst_pkg::MAX32 : w_pk_sum[31:0];
        w_new.bytes     = w_by_sum[48] ? fst_pkg::MAX48 : w_by_sum[47:0];
        w_new.seen_at   = r_item.now;
    end

    // Write port source: clearing pass, eviction or flow update.
    always_comb begin
        w_wr_idx  = w_upd_idx;
        w_wr_data = w_new;
        if (r_state == fst_pkg::S_CLEAR) begin
            w_wr_idx  = w_idx;
            w_wr_data = '0;
        end else if (r_state != fst_pkg::S_UPDATE) begin
            w_wr_idx        = r_rd_idx;
            w_wr_data       = r_rd_data;
            w_wr_data.valid = 1'b0;
        end
    end

    // Memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_idx];
        end
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fst_pkg::S_CLEAR;
            r_live   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (r_state == fst_pkg::S_UPDATE && !r_hit && r_free) begin
                r_live <= r_live + CW'(1);
            end else if (w_evict) begin
                r_live <= r_live - CW'(1);
            end
        end
    end

    // Item and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_idx;
        if (!i_rst_n || r_state == fst_pkg::S_IDLE) begin
            r_addr <= '0;
        end else if (w_rd_en || r_state == fst_pkg::S_CLEAR) begin
            r_addr <= r_addr + (AW+1)'(1);
        end
        case (r_state)
            fst_pkg::S_IDLE: begin
                r_item  <= i_item;
                r_hit   <= 1'b0;
                r_free  <= 1'b0;
                r_evict <= '0;
            end
            fst_pkg::S_SCAN, fst_pkg::S_SCAN_WAIT: begin
                if (w_key_eq) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (r_rd_vld && !r_rd_data.valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
            fst_pkg::S_SWEEP, fst_pkg::S_SWEEP_WAIT: begin
                if (w_evict) begin
                    r_evict <= r_evict + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // Result register, built once the table is settled.
    always_ff @(posedge i_clk) begin
        if (r_state == fst_pkg::S_UPDATE) begin
            r_res.evicted_count <= '0;
            if (r_hit || r_free) begin
                r_res.status       <= r_hit ? fst_pkg::ST_UPDATED : fst_pkg::ST_CREATED;
                r_res.flow_packets <= w_new.packets;
                r_res.flow_bytes   <= w_new.bytes;
                r_res.live_count   <= 11'(r_live + (r_hit ? CW'(0) : CW'(1)));
            end else begin
                r_res.status       <= fst_pkg::ST_DROPPED;
                r_res.flow_packets <= '0;
                r_res.flow_bytes   <= '0;
                r_res.live_count   <= 11'(r_live);
            end
        end else if (r_state == fst_pkg::S_SWEEP_WAIT) begin
            r_res.status        <= fst_pkg::ST_SWEPT;
            r_res.flow_packets  <= '0;
            r_res.flow_bytes    <= '0;
            r_res.live_count    <= 11'(r_live - (w_evict ? CW'(1) : CW'(0)));
            r_res.evicted_count <= 11'(r_evict + (w_evict ? CW'(1) : CW'(0)));
        end
    end

    assign o_res = r_res;

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == fst_pkg::S_IDLE) else $error("take outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_take) |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(ENTRIES)) else $error("live count over table size");

endmodule
